// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define FNQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define FNQ_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define FNQ_ASSERT(label, clk, rst, prop, msg)
`define FNQ_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== hdl/fnq_pkg.sv =====
// ----------------------------------------------------------------------------
// fnq_pkg
// shared widths, action and register codes, and the result beat type
// ----------------------------------------------------------------------------
`default_nettype none

package fnq_pkg;

   // field widths
   localparam int ACT_W      = 2;
   localparam int ID_W       = 32;
   localparam int DATA_W     = 32;
   localparam int CLASS_W    = 6;
   localparam int VER_W      = 9;
   localparam int MASK_W     = 64;
   localparam int ENTRY_W    = ID_W + DATA_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;

   // action codes
   localparam logic [ACT_W-1:0] ACT_PUSH      = 2'd0;
   localparam logic [ACT_W-1:0] ACT_POP_FIRST = 2'd1;
   localparam logic [ACT_W-1:0] ACT_POP_ID    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_MASK    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEWEST_VERSION = 1'd1;

   // one result beat
   typedef struct packed {
      logic              accepted;
      logic              filtered;
      logic              overflow;
      logic [ID_W-1:0]   got_id;
      logic [DATA_W-1:0] got_data;
      logic              pending;
   } fnq_result_type;

endpackage

`default_nettype wire

// ===== hdl/filtered_notification_queue.sv =====
// ----------------------------------------------------------------------------
// filtered_notification_queue
// ordered notification queue with class/version filter and dequeue by id
// ----------------------------------------------------------------------------
// usage
//   req_ channel carries one action per beat: enqueue, dequeue oldest, or
//   dequeue oldest with a matching id. rsp_ returns one result beat for
//   every request beat, in order. csr_ writes the class mask (index 0) and
//   the newest accepted version (index 1). The user must write them only while
//   the block is idle; the block itself does not enforce it.
// sequencing
//   enqueue and unused codes pass the start and done states; a dequeue
//   also runs the scan and compaction loop, which reads or moves one ram
//   entry a cycle over the n entries held (at most QUEUE_DEPTH).
//   req_stall is high while a beat is in work, so one beat is handled at a
//   time; the next one is taken as soon as the result sits in the output
//   register, even while rsp_stall holds it.
// reset
//   queue empties, both filter registers clear, no result is pending.
// receiver stall: the result register holds; a finished beat waits until it frees.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_notification_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [fnq_pkg::ACT_W-1:0]         req_action,
   input  wire logic [fnq_pkg::ID_W-1:0]          req_note_id,
   input  wire logic [fnq_pkg::DATA_W-1:0]        req_note_data,
   input  wire logic [fnq_pkg::CLASS_W-1:0]       req_class_index,
   input  wire logic [fnq_pkg::VER_W-1:0]         req_note_version,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_accepted,
   output logic                                   rsp_filtered,
   output logic                                   rsp_overflow,
   output logic      [fnq_pkg::ID_W-1:0]          rsp_got_id,
   output logic      [fnq_pkg::DATA_W-1:0]        rsp_got_data,
   output logic                                   rsp_pending,
   // register write port
   input  wire logic                              csr_wr_en,
   input  wire logic [fnq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fnq_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   import fnq_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic               filter_pass;
   logic               eng_busy;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   logic               done_valid;
   fnq_result_type     done_result;
   logic               slot_free;

   logic               rsp_valid_ff, rsp_valid_in;
   fnq_result_type     rsp_res_ff, rsp_res_in;

   // filter registers
   fnq_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .class_index  (req_class_index),
      .note_version (req_note_version),
      .filter_pass  (filter_pass)
   );

   // sequencer
   fnq_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_action    (req_action),
      .req_note_id   (req_note_id),
      .req_note_data (req_note_data),
      .filter_pass   (filter_pass),
      .busy          (eng_busy),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .done_valid    (done_valid),
      .done_result   (done_result),
      .slot_free     (slot_free)
   );

   // entry storage, oldest entry at address zero
   fnq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = reset || eng_busy;

   // output register
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (done_valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = done_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_res_ff.accepted;
   assign rsp_filtered = rsp_res_ff.filtered;
   assign rsp_overflow = rsp_res_ff.overflow;
   assign rsp_got_id   = rsp_res_ff.got_id;
   assign rsp_got_data = rsp_res_ff.got_data;
   assign rsp_pending  = rsp_res_ff.pending;

endmodule

`default_nettype wire

// ===== hdl/fnq_ram.sv =====
// ----------------------------------------------------------------------------
// fnq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fnq_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/fnq_cfg.sv =====
// ----------------------------------------------------------------------------
// fnq_cfg
// filter registers and the class mask / version check of an incoming beat
// ----------------------------------------------------------------------------
`default_nettype none

module fnq_cfg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [fnq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fnq_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  wire logic [fnq_pkg::CLASS_W-1:0]       class_index,
   input  wire logic [fnq_pkg::VER_W-1:0]         note_version,
   output logic                                   filter_pass
);

   import fnq_pkg::*;

   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [VER_W-1:0]  version_ff, version_in;

   // register write decode
   always_comb begin
      mask_in    = mask_ff;
      version_in = version_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACCEPT_MASK:    mask_in    = csr_wr_data[MASK_W-1:0];
            CSR_NEWEST_VERSION: version_in = csr_wr_data[VER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= '0;
         version_ff <= '0;
      end else begin
         mask_ff    <= mask_in;
         version_ff <= version_in;
      end
   end

   // class enabled and version not newer than allowed
   assign filter_pass = mask_ff[class_index] && (note_version <= version_ff);

endmodule

`default_nettype wire

// ===== hdl/fnq_engine.sv =====
// ----------------------------------------------------------------------------
// fnq_engine
// queue sequencer: append, scan with one shared id compare, then compaction
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fnq_engine #(
   parameter int QUEUE_DEPTH = 16,
   parameter int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input beat
   input  wire logic                           req_valid,
   input  wire logic [fnq_pkg::ACT_W-1:0]      req_action,
   input  wire logic [fnq_pkg::ID_W-1:0]       req_note_id,
   input  wire logic [fnq_pkg::DATA_W-1:0]     req_note_data,
   input  wire logic                           filter_pass,
   output logic                                busy,
   // entry ram
   output logic                                ram_we,
   output logic      [IDX_W-1:0]               ram_waddr,
   output logic      [fnq_pkg::ENTRY_W-1:0]    ram_wdata,
   output logic      [IDX_W-1:0]               ram_raddr,
   input  wire logic [fnq_pkg::ENTRY_W-1:0]    ram_rdata,
   // finished result
   output logic                                done_valid,
   output fnq_pkg::fnq_result_type             done_result,
   input  wire logic                           slot_free
);

   import fnq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              pass_ff, pass_in;
   fnq_result_type    res_ff, res_in;

   logic [CNT_W-1:0]  ptr_nxt;
   logic [CNT_W-1:0]  ptr_prv;
   logic              more;
   logic              hit;
   logic              full;

   assign ptr_nxt = ptr_ff + CNT_W'(1);
   assign ptr_prv = ptr_ff - CNT_W'(1);
   assign more    = ptr_nxt < count_ff;
   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);

   // shared compare: the entry just read is the one to remove
   assign hit = (act_ff == ACT_POP_FIRST) || (ram_rdata[ENTRY_W-1:DATA_W] == id_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      act_in    = act_ff;
      id_in     = id_ff;
      data_in   = data_ff;
      pass_in   = pass_ff;
      res_in    = res_ff;
      ram_we    = 1'b0;
      ram_waddr = ptr_prv[IDX_W-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = ptr_nxt[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               id_in    = req_note_id;
               data_in  = req_note_data;
               pass_in  = filter_pass;
               res_in   = '0;
               state_in = S_START;
            end
         end

         S_START: begin
            case (act_ff) inside
               ACT_PUSH: begin
                  if (!pass_ff) begin
                     res_in.filtered = 1'b1;
                  end else if (full) begin
                     res_in.overflow = 1'b1;
                  end else begin
                     ram_we          = 1'b1;
                     ram_waddr       = count_ff[IDX_W-1:0];
                     ram_wdata       = {id_ff, data_ff};
                     count_in        = count_ff + CNT_W'(1);
                     res_in.accepted = 1'b1;
                  end
                  state_in = S_DONE;
               end
               ACT_POP_FIRST, ACT_POP_ID: begin
                  ram_raddr = '0;
                  ptr_in    = '0;
                  state_in  = (count_ff == '0) ? S_DONE : S_SCAN;
               end
               default: state_in = S_DONE;
            endcase
         end

         // read data of entry ptr is present
         S_SCAN: begin
            if (hit) begin
               res_in.accepted = 1'b1;
               res_in.got_id   = ram_rdata[ENTRY_W-1:DATA_W];
               res_in.got_data = ram_rdata[DATA_W-1:0];
               if (more) begin
                  ptr_in   = ptr_nxt;
                  state_in = S_SHIFT;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_DONE;
               end
            end else if (more) begin
               ptr_in = ptr_nxt;
            end else begin
               state_in = S_DONE;
            end
         end

         // move entry ptr one place toward the head
         S_SHIFT: begin
            ram_we = 1'b1;
            if (more) begin
               ptr_in = ptr_nxt;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      act_ff  <= act_in;
      id_ff   <= id_in;
      data_ff <= data_in;
      pass_ff <= pass_in;
      res_ff  <= res_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign done_valid = state_ff == S_DONE;

   // pending reflects the count after this beat
   always_comb begin
      done_result         = res_ff;
      done_result.pending = count_ff != '0;
   end

   `FNQ_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(QUEUE_DEPTH), "entry count above depth")
   `FNQ_ASSERT(a_accept_start, clock, reset, (state_ff == S_IDLE) && req_valid |=> (state_ff == S_START), "accepted beat did not start")
   `FNQ_ASSERT_NEVER(a_write_quiet, clock, reset, ram_we && ((state_ff == S_IDLE) || (state_ff == S_DONE)), "ram write outside work")
   `FNQ_ASSERT_NEVER(a_ptr_range, clock, reset, ((state_ff == S_SCAN) || (state_ff == S_SHIFT)) && (ptr_ff >= count_ff), "scan pointer beyond count")
   `FNQ_ASSERT(a_shift_ptr, clock, reset, (state_ff == S_SHIFT) |-> (ptr_ff != '0), "shift from head entry")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for filtered_notification_queue
//
// A short table of directed beats runs first: an empty queue, the filter
// extremes, a full queue with overflow, and dequeues that hit or miss. Random
// phases follow, each with its own filter setting. A queue-based copy of the
// notification list predicts every result beat, and each beat from the block
// is compared field by field with the oldest prediction. The sender works in
// bursts and the receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module tb;
   import fnq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 100;
   localparam int SETTLE         = 4;
   localparam int TAIL           = 40;
   localparam int HOLD_AT        = 350;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SHOWN_FAULTS   = 10;

   // action code the block ignores
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef enum {ROW_REQ, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [ACT_W-1:0]          act;
      logic [ID_W-1:0]           id;
      logic [DATA_W-1:0]         data;
      logic [CLASS_W-1:0]        cls;
      logic [VER_W-1:0]          ver;
      int                        reps;
      bit                        typed;
      fnq_result_type            want;
      logic [CSR_IDX_W-1:0]      reg_idx;
      logic [CSR_DATA_W-1:0]     reg_val;
   } plan_row_type;

   typedef struct {
      logic [ID_W-1:0]   note_id;
      logic [DATA_W-1:0] note_data;
   } note_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [ACT_W-1:0]      req_action;
   logic [ID_W-1:0]       req_note_id;
   logic [DATA_W-1:0]     req_note_data;
   logic [CLASS_W-1:0]    req_class_index;
   logic [VER_W-1:0]      req_note_version;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_accepted;
   logic                  rsp_filtered;
   logic                  rsp_overflow;
   logic [ID_W-1:0]       rsp_got_id;
   logic [DATA_W-1:0]     rsp_got_data;
   logic                  rsp_pending;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   // typed expectation traveling with the request beat
   bit                    cur_typed;
   fnq_result_type        cur_want;

   // predictor state
   logic [MASK_W-1:0]     mask_copy   = '0;
   logic [VER_W-1:0]      newest_copy = '0;
   note_type              held_notes[$];
   fnq_result_type        due_results[$];

   plan_row_type          plan[$];
   int                    fault_count = 0;
   int                    beats_out   = 0;
   int                    quiet_cycles = 0;

   filtered_notification_queue #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_note_id      (req_note_id),
      .req_note_data    (req_note_data),
      .req_class_index  (req_class_index),
      .req_note_version (req_note_version),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_filtered     (rsp_filtered),
      .rsp_overflow     (rsp_overflow),
      .rsp_got_id       (rsp_got_id),
      .rsp_got_data     (rsp_got_data),
      .rsp_pending      (rsp_pending),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   // apply one action to the notification list and return its result beat
   function automatic fnq_result_type apply_action(logic [ACT_W-1:0] act,
         logic [ID_W-1:0] id, logic [DATA_W-1:0] data, logic [CLASS_W-1:0] cls,
         logic [VER_W-1:0] ver);
      fnq_result_type r;
      note_type       nt;
      int             hit;
      r   = '0;
      hit = -1;
      case (act)
         ACT_PUSH: begin
            if (!mask_copy[cls] || ver > newest_copy)
               r.filtered = 1'b1;
            else if (held_notes.size() >= DEPTH)
               r.overflow = 1'b1;
            else begin
               nt.note_id   = id;
               nt.note_data = data;
               held_notes.insert(held_notes.size(), nt);
               r.accepted = 1'b1;
            end
         end
         ACT_POP_FIRST: begin
            if (held_notes.size() > 0)
               hit = 0;
         end
         ACT_POP_ID: begin
            // scan from the back so the oldest match wins
            for (int i = held_notes.size() - 1; i >= 0; i--)
               if (held_notes[i].note_id == id)
                  hit = i;
         end
         default: ;
      endcase
      if (hit >= 0) begin
         r.accepted = 1'b1;
         r.got_id   = held_notes[hit].note_id;
         r.got_data = held_notes[hit].note_data;
         held_notes.delete(hit);
      end
      r.pending = (held_notes.size() != 0);
      return r;
   endfunction

   function automatic fnq_result_type outcome(bit acc, bit flt, bit ovf,
         logic [ID_W-1:0] id, logic [DATA_W-1:0] data, bit pend);
      fnq_result_type r;
      r = {acc, flt, ovf, id, data, pend};
      return r;
   endfunction

   function automatic void add_req(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
         logic [DATA_W-1:0] data, logic [CLASS_W-1:0] cls, logic [VER_W-1:0] ver,
         int reps, bit typed, fnq_result_type want);
      plan_row_type row;
      row         = '{kind: ROW_REQ, default: '0};
      row.act     = act;
      row.id      = id;
      row.data    = data;
      row.cls     = cls;
      row.ver     = ver;
      row.reps    = reps;
      row.typed   = typed;
      row.want    = want;
      plan.insert(plan.size(), row);
   endfunction

   function automatic void add_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      plan_row_type row;
      row         = '{kind: ROW_REG, default: '0};
      row.reg_idx = idx;
      row.reg_val = val;
      plan.insert(plan.size(), row);
   endfunction

   task automatic note_failure(string msg);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS)
         $display("%s", msg);
   endtask

   // offer one beat and hold it until the block takes it
   task automatic offer(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
         logic [DATA_W-1:0] data, logic [CLASS_W-1:0] cls, logic [VER_W-1:0] ver,
         bit typed, fnq_result_type want);
      req_valid        <= 1'b1;
      req_action       <= act;
      req_note_id      <= id;
      req_note_data    <= data;
      req_class_index  <= cls;
      req_note_version <= ver;
      cur_typed        <= typed;
      cur_want         <= want;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // stop sending and wait until every predicted beat has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // caller lowers the write enable after the last write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   task automatic set_filter(logic [MASK_W-1:0] mask, logic [VER_W-1:0] ver);
      wait_for_results();
      write_reg(CSR_ACCEPT_MASK, mask);
      write_reg(CSR_NEWEST_VERSION, CSR_DATA_W'(ver));
      csr_wr_en <= 1'b0;
   endtask

   // register shadow, result check and prediction
   always @(posedge clock) begin : track
      fnq_result_type got;
      fnq_result_type want;
      string          bad;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ACCEPT_MASK:    mask_copy   = csr_wr_data;
               CSR_NEWEST_VERSION: newest_copy = csr_wr_data[VER_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            got = {rsp_accepted, rsp_filtered, rsp_overflow, rsp_got_id, rsp_got_data,
                   rsp_pending};
            if (due_results.size() == 0) begin
               note_failure($sformatf("result beat %0d arrived with nothing expected",
                                      beats_out));
            end else begin
               want = due_results.pop_front();
               bad  = "";
               if (got.accepted !== want.accepted) bad = {bad, " accepted"};
               if (got.filtered !== want.filtered) bad = {bad, " filtered"};
               if (got.overflow !== want.overflow) bad = {bad, " overflow"};
               if (got.got_id   !== want.got_id)   bad = {bad, " got_id"};
               if (got.got_data !== want.got_data) bad = {bad, " got_data"};
               if (got.pending  !== want.pending)  bad = {bad, " pending"};
               if (bad != "")
                  note_failure($sformatf(
                     {"beat %0d mismatch on%s: exp acc=%b flt=%b ovf=%b id=%h data=%h",
                      " pend=%b, got acc=%b flt=%b ovf=%b id=%h data=%h pend=%b"},
                     beats_out, bad, want.accepted, want.filtered, want.overflow,
                     want.got_id, want.got_data, want.pending, got.accepted,
                     got.filtered, got.overflow, got.got_id, got.got_data,
                     got.pending));
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_action(req_action, req_note_id, req_note_data,
                                req_class_index, req_note_version);
            if (cur_typed)
               want = cur_want;
            due_results.insert(due_results.size(), want);
         end
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: stall stretches, free stretches, one long hold-off
   initial begin
      int  stall_left;
      int  free_left;
      bit  hold_done;
      rsp_stall  = 1'b0;
      stall_left = 0;
      free_left  = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && beats_out >= HOLD_AT) begin
            stall_left = LONG_HOLD;
            free_left  = 0;
            hold_done  = 1'b1;
         end else if (stall_left == 0 && free_left == 0) begin
            free_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            stall_left = $urandom_range(1, 6);
         end
         if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else begin
            rsp_stall <= 1'b1;
            stall_left--;
         end
      end
   end

   // stimulus
   initial begin
      bit                 writing;
      int                 push_pct;
      int                 burst;
      int                 roll;
      bit                 gappy;
      logic [MASK_W-1:0]  mask;
      logic [VER_W-1:0]   newest;
      logic [ACT_W-1:0]   act;
      logic [ID_W-1:0]    id;
      logic [DATA_W-1:0]  data;
      logic [CLASS_W-1:0] cls;
      logic [VER_W-1:0]   ver;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACT_PUSH;
      req_note_id      = '0;
      req_note_data    = '0;
      req_class_index  = '0;
      req_note_version = '0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_ACCEPT_MASK;
      csr_wr_data      = '0;
      cur_typed        = 1'b0;
      cur_want         = '0;

      // empty queue with the reset filter: nothing passes
      add_req(ACT_POP_FIRST, '0, '0, 6'd0, 9'd0, 1, 1, outcome(0, 0, 0, '0, '0, 0));
      add_req(ACT_PUSH, 32'h1, 32'h2, 6'd0, 9'd0, 1, 1, outcome(0, 1, 0, '0, '0, 0));
      add_req(ACT_UNUSED, '1, '1, 6'd63, 9'd511, 1, 1, outcome(0, 0, 0, '0, '0, 0));
      // open filter, fill the queue, then overflow
      add_reg(CSR_ACCEPT_MASK, '1);
      add_reg(CSR_NEWEST_VERSION, 64'd511);
      add_req(ACT_PUSH, '1, '1, 6'd63, 9'd511, 1, 1, outcome(1, 0, 0, '0, '0, 1));
      add_req(ACT_PUSH, '0, '0, 6'd0, 9'd0, 1, 1, outcome(1, 0, 0, '0, '0, 1));
      add_req(ACT_PUSH, 32'h0000_1000, 32'h5a5a_0000, 6'd1, 9'd7, 14, 0, '0);
      add_req(ACT_PUSH, 32'ha5a5_a5a5, 32'h0f0f_0f0f, 6'd21, 9'd256, 1, 1,
              outcome(0, 0, 1, '0, '0, 1));
      // filter is checked before fullness
      add_reg(CSR_ACCEPT_MASK, 64'h7fff_ffff_ffff_ffff);
      add_reg(CSR_NEWEST_VERSION, 64'd100);
      add_req(ACT_PUSH, 32'h2, 32'h3, 6'd63, 9'd0, 1, 1, outcome(0, 1, 0, '0, '0, 1));
      add_req(ACT_PUSH, 32'h4, 32'h5, 6'd0, 9'd101, 1, 1, outcome(0, 1, 0, '0, '0, 1));
      add_req(ACT_PUSH, 32'h6, 32'h7, 6'd62, 9'd100, 1, 1, outcome(0, 0, 1, '0, '0, 1));
      // dequeues: hit by id, miss by id, oldest, ignored code, middle entry
      add_req(ACT_POP_ID, '1, '0, 6'd0, 9'd0, 1, 1, outcome(1, 0, 0, '1, '1, 1));
      add_req(ACT_POP_ID, 32'hdead_beef, '1, 6'd63, 9'd511, 1, 1,
              outcome(0, 0, 0, '0, '0, 1));
      add_req(ACT_POP_FIRST, '1, '1, 6'd63, 9'd511, 1, 1, outcome(1, 0, 0, '0, '0, 1));
      add_req(ACT_UNUSED, '0, '0, 6'd0, 9'd0, 1, 1, outcome(0, 0, 0, '0, '0, 1));
      add_req(ACT_POP_ID, 32'h0000_1005, '0, 6'd0, 9'd0, 1, 0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      writing = 1'b0;
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_REG) begin
            if (!writing)
               wait_for_results();
            write_reg(plan[r].reg_idx, plan[r].reg_val);
            writing = 1'b1;
         end else begin
            if (writing) begin
               csr_wr_en <= 1'b0;
               writing = 1'b0;
            end
            for (int k = 0; k < plan[r].reps; k++) begin
               offer(plan[r].act, plan[r].id + k, plan[r].data ^ k,
                     plan[r].cls + CLASS_W'(k), plan[r].ver, plan[r].typed,
                     plan[r].want);
               pause($urandom_range(0, 2));
            end
         end
      end

      // random phases, each with its own filter and action mix
      for (int phase = 0; phase < PHASES; phase++) begin
         gappy = 1'b1;
         case (phase)
            0: begin mask = '1; newest = 9'd511; push_pct = 60; end
            1: begin mask = '0; newest = 9'd0; push_pct = 50; end
            2: begin mask = {$urandom, $urandom}; newest = VER_W'($urandom_range(0, 511));
                  push_pct = 70; end
            3: begin mask = 64'd1 << $urandom_range(0, 63); newest = 9'd0;
                  push_pct = 55; end
            4: begin mask = {$urandom, $urandom}; newest = 9'd511; push_pct = 40; end
            5: begin mask = '1; newest = VER_W'($urandom_range(0, 511)); push_pct = 65;
                  gappy = 1'b0; end
            6: begin mask = {$urandom, $urandom}; newest = VER_W'($urandom_range(0, 511));
                  push_pct = 30; end
            default: begin mask = '1; newest = 9'd511; push_pct = 50; end
         endcase
         set_filter(mask, newest);
         burst = $urandom_range(1, 20);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // one pause mid-phase until everything has come back
            if (phase == 2 && n == PHASE_ITEMS / 2)
               wait_for_results();
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
               act = ACT_PUSH;
            else if (roll < push_pct + (96 - push_pct) / 2)
               act = ACT_POP_FIRST;
            else if (roll < 96)
               act = ACT_POP_ID;
            else
               act = ACT_UNUSED;
            // small id pool so dequeue-by-id finds duplicates and matches
            id = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
            if (act == ACT_POP_ID && held_notes.size() > 0 && $urandom_range(0, 3) != 0)
               id = held_notes[$urandom_range(0, held_notes.size() - 1)].note_id;
            data = $urandom;
            cls  = CLASS_W'($urandom_range(0, 63));
            if (mask != '0 && $urandom_range(0, 4) != 0) begin
               while (!mask[cls])
                  cls = cls + 1'b1;
            end
            ver = VER_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, newest)
                                                     : $urandom_range(0, 511));
            offer(act, id, data, cls, ver, 1'b0, '0);
            burst--;
            if (burst == 0) begin
               burst = $urandom_range(1, 20);
               if (gappy)
                  pause(($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 6));
            end
         end
      end

      wait_for_results();
      repeat (TAIL) @(posedge clock);
      if (fault_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
